@@ rtl/core/crpr_pkg.sv @@
// Package for the Catmull-Rom point resampler.
// Holds the basis weight table, division constants and shared types.
// No dependencies.
`default_nettype none

package crpr_pkg;

    localparam int COORD_WIDTH_DEF  = 24;
    localparam int NUM_TAPS         = 4;
    localparam int WIN_DEPTH        = 3;
    localparam int SAMPLE_IDX_W     = 3;
    localparam logic [SAMPLE_IDX_W-1:0] LAST_SAMPLE_IDX = 3'd6;

    // Weights are the basis numerators halved; they sum to DIVISOR.
    localparam int WEIGHT_W         = 10;
    localparam int DIVISOR          = 343;
    localparam int ROUND_BIAS       = 171;
    // Magnitude of a weighted sum stays below 2^(COORD_WIDTH + HEAD_W).
    localparam int HEAD_W           = 8;
    // 2^RECIP_SHIFT is at least DIVISOR.
    localparam int RECIP_SHIFT      = 9;
    // Register stages of one coordinate lane.
    localparam int LANE_STAGES      = 5;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t [NUM_TAPS-1:0] weight_set_t;

    typedef struct packed {
        logic advance;
    } crpr_ctrl_t;

    function automatic weight_set_t basis_weights(input logic [SAMPLE_IDX_W-1:0] j);
        weight_set_t w;
        case (j)
            3'd0:
            begin
                w[0] = WEIGHT_W'(0);   w[1] = WEIGHT_W'(343);
                w[2] = WEIGHT_W'(0);   w[3] = WEIGHT_W'(0);
            end
            3'd1:
            begin
                w[0] = WEIGHT_W'(-18); w[1] = WEIGHT_W'(327);
                w[2] = WEIGHT_W'(37);  w[3] = WEIGHT_W'(-3);
            end
            3'd2:
            begin
                w[0] = WEIGHT_W'(-25); w[1] = WEIGHT_W'(285);
                w[2] = WEIGHT_W'(93);  w[3] = WEIGHT_W'(-10);
            end
            3'd3:
            begin
                w[0] = WEIGHT_W'(-24); w[1] = WEIGHT_W'(226);
                w[2] = WEIGHT_W'(159); w[3] = WEIGHT_W'(-18);
            end
            3'd4:
            begin
                w[0] = WEIGHT_W'(-18); w[1] = WEIGHT_W'(159);
                w[2] = WEIGHT_W'(226); w[3] = WEIGHT_W'(-24);
            end
            3'd5:
            begin
                w[0] = WEIGHT_W'(-10); w[1] = WEIGHT_W'(93);
                w[2] = WEIGHT_W'(285); w[3] = WEIGHT_W'(-25);
            end
            3'd6:
            begin
                w[0] = WEIGHT_W'(-3);  w[1] = WEIGHT_W'(37);
                w[2] = WEIGHT_W'(327); w[3] = WEIGHT_W'(-18);
            end
            default:
            begin
                w[0] = WEIGHT_W'(0);   w[1] = WEIGHT_W'(343);
                w[2] = WEIGHT_W'(0);   w[3] = WEIGHT_W'(0);
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/crpr_point_if.sv @@
// Control point channel of the Catmull-Rom point resampler.
// Depends on crpr_pkg for the default coordinate width.
`default_nettype none

interface crpr_point_if
    import crpr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          end_of_stroke;

    modport source (output valid, output point_x, output point_y, output end_of_stroke,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input end_of_stroke,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/crpr_sample_if.sv @@
// Sample channel of the Catmull-Rom point resampler.
// Depends on crpr_pkg for the default coordinate width.
`default_nettype none

interface crpr_sample_if
    import crpr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] sample_x;
    logic signed [COORD_WIDTH-1:0] sample_y;
    logic                          final_sample;

    modport source (output valid, output sample_x, output sample_y, output final_sample,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input final_sample,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/crpr_lane.sv @@
// One coordinate lane: weighted sum, rounding and division by the basis
// denominator through a split reciprocal multiply, then saturation. Depends on crpr_pkg.
`default_nettype none

module crpr_lane
    import crpr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  crpr_ctrl_t                    ctrl,
    input  weight_set_t                   weights,
    input  logic signed [COORD_WIDTH-1:0] taps [NUM_TAPS],
    output logic signed [COORD_WIDTH-1:0] result
);

    localparam int PW = COORD_WIDTH + WEIGHT_W;
    localparam int DW = COORD_WIDTH + HEAD_W;
    localparam int LW = DW / 2;
    localparam int HW = DW - LW;
    localparam int RW = DW + 1;
    localparam int FW = 2 * DW + 1;

    localparam logic [COORD_WIDTH-1:0] MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MIN_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    // Reciprocal of DIVISOR scaled by 2^(DW + RECIP_SHIFT), rounded up.
    localparam logic [RW-1:0]          RECIP   =
        RW'(((64'd1 << (DW + RECIP_SHIFT)) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

    logic signed [PW-1:0]    prod_reg [NUM_TAPS];
    logic signed [PW-1:0]    sum_reg;
    logic [DW-1:0]           mag_reg;
    logic                    neg_reg;
    logic [LW+RW-1:0]        lo_reg;
    logic [HW+RW-1:0]        hi_reg;
    logic                    neg_mul_reg;
    logic [COORD_WIDTH-1:0]  quo_reg;
    logic                    neg_quo_reg;
    logic [PW-1:0]           abs_val;
    logic [PW-1:0]           mag_val;
    logic [FW-1:0]           full_val;

    always_comb
    begin
        abs_val  = sum_reg[PW-1] ? PW'(-sum_reg) : PW'(sum_reg);
        mag_val  = abs_val + PW'(ROUND_BIAS);
        full_val = {hi_reg, {LW{1'b0}}} + FW'(lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                prod_reg[k] <= PW'($signed(weights[k])) * PW'(taps[k]);
            end
            sum_reg     <= prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3];
            mag_reg     <= mag_val[DW-1:0];
            neg_reg     <= sum_reg[PW-1];
            lo_reg      <= (LW+RW)'(mag_reg[LW-1:0]) * (LW+RW)'(RECIP);
            hi_reg      <= (HW+RW)'(mag_reg[DW-1:LW]) * (HW+RW)'(RECIP);
            neg_mul_reg <= neg_reg;
            quo_reg     <= full_val[FW-1:DW+RECIP_SHIFT];
            neg_quo_reg <= neg_mul_reg;
        end
    end

    // Clamp the rounded quotient to the signed coordinate range.
    always_comb
    begin
        if (!neg_quo_reg)
        begin
            result = (quo_reg > MAX_POS) ? MAX_POS : quo_reg;
        end
        else
        begin
            result = (quo_reg > MIN_NEG) ? MIN_NEG : COORD_WIDTH'(-quo_reg);
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/catmull_rom_point_resampler.sv @@
// Top level of the Catmull-Rom point resampler: stroke window, segment
// sequencer and output register. Depends on crpr_pkg, crpr_point_if,
// crpr_sample_if and crpr_lane.
//
// Usage:
//  points  : control points of a stroke, one item per point, end_of_stroke
//            set on the last point of the stroke.
//  samples : seven interpolated samples per segment (t = j/7), and after the
//            last point that point itself with final_sample set.
//  An item yields seven samples from the third point of a stroke on, two
//  segments and the end point on the last point, one segment and the end point
//  on the last point of a two-point stroke, and nothing for the first and second
//  point and a one-point stroke. The segment sequencer emits one sample a cycle
//  while samples does not stall; a new point is taken in the cycle its last sample
//  leaves the sequencer.
//  A point's first sample passes, after acceptance, through the tap registers,
//  multiply, sum, rounding, two reciprocal-multiply stages, output register.
//  Reset clears the window, the point count, the sequencer and all valids.
//  A stall on samples freezes the whole sample pipeline; points is still
//  taken while the sequencer is idle.
`default_nettype none

module catmull_rom_point_resampler
    import crpr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    crpr_point_if.sink    points,
    crpr_sample_if.source samples
);

    localparam int LAT = LANE_STAGES;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    coord_t                    win_x_reg [WIN_DEPTH];
    coord_t                    win_y_reg [WIN_DEPTH];
    coord_t                    win_x_next [WIN_DEPTH];
    coord_t                    win_y_next [WIN_DEPTH];
    logic [1:0]                ps_reg;
    logic [1:0]                ps_next;

    coord_t                    px_reg [NUM_TAPS];
    coord_t                    py_reg [NUM_TAPS];
    coord_t                    px_next [NUM_TAPS];
    coord_t                    py_next [NUM_TAPS];
    logic                      active_reg;
    logic                      active_next;
    logic                      fin_phase_reg;
    logic                      fin_phase_next;
    logic                      seg_b_reg;
    logic                      seg_b_next;
    logic                      fin_pend_reg;
    logic                      fin_pend_next;
    logic [SAMPLE_IDX_W-1:0]   j_reg;
    logic [SAMPLE_IDX_W-1:0]   j_next;

    logic [LAT-1:0]            vld_reg;
    logic [LAT-1:0]            fin_reg;
    logic                      out_vld_reg;
    logic                      out_fin_reg;
    coord_t                    out_x_reg;
    coord_t                    out_y_reg;

    crpr_ctrl_t                ctrl;
    logic                      advance;
    logic                      last_emit;
    logic                      accept;
    weight_set_t               weights;
    coord_t                    lane_px [NUM_TAPS];
    coord_t                    lane_py [NUM_TAPS];
    coord_t                    res_x;
    coord_t                    res_y;

    assign advance      = !out_vld_reg || samples.ready;
    assign ctrl.advance = advance;
    assign last_emit    = active_reg && (fin_phase_reg ||
                          (j_reg == LAST_SAMPLE_IDX && !seg_b_reg && !fin_pend_reg));
    assign points.ready = !active_reg || (advance && last_emit);
    assign accept       = points.valid && points.ready;

    // End point goes through the j = 0 weights, which return tap 1 exactly.
    assign weights = basis_weights(j_reg);
    always_comb
    begin
        lane_px = px_reg;
        lane_py = py_reg;
        if (fin_phase_reg)
        begin
            lane_px[1] = px_reg[3];
            lane_py[1] = py_reg[3];
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        fin_phase_next = fin_phase_reg;
        seg_b_next     = seg_b_reg;
        fin_pend_next  = fin_pend_reg;
        j_next         = j_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        win_x_next     = win_x_reg;
        win_y_next     = win_y_reg;
        ps_next        = ps_reg;

        if (active_reg && advance)
        begin
            if (fin_phase_reg)
            begin
                active_next    = 1'b0;
                fin_phase_next = 1'b0;
            end
            else if (j_reg == LAST_SAMPLE_IDX)
            begin
                j_next = '0;
                if (seg_b_reg)
                begin
                    // Slide to the closing segment: last point doubled.
                    px_next[0] = px_reg[1];
                    px_next[1] = px_reg[2];
                    px_next[2] = px_reg[3];
                    py_next[0] = py_reg[1];
                    py_next[1] = py_reg[2];
                    py_next[2] = py_reg[3];
                    seg_b_next = 1'b0;
                end
                else if (fin_pend_reg)
                begin
                    fin_phase_next = 1'b1;
                    fin_pend_next  = 1'b0;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                j_next = j_reg + SAMPLE_IDX_W'(1);
            end
        end

        if (accept)
        begin
            j_next         = '0;
            fin_phase_next = 1'b0;
            seg_b_next     = 1'b0;
            fin_pend_next  = 1'b0;
            active_next    = 1'b0;
            if (ps_reg >= 2'd2)
            begin
                active_next   = 1'b1;
                seg_b_next    = points.end_of_stroke;
                fin_pend_next = points.end_of_stroke;
                px_next[0]    = (ps_reg == 2'd3) ? win_x_reg[0] : win_x_reg[1];
                py_next[0]    = (ps_reg == 2'd3) ? win_y_reg[0] : win_y_reg[1];
                px_next[1]    = win_x_reg[1];
                py_next[1]    = win_y_reg[1];
                px_next[2]    = win_x_reg[2];
                py_next[2]    = win_y_reg[2];
                px_next[3]    = points.point_x;
                py_next[3]    = points.point_y;
            end
            else if (points.end_of_stroke && ps_reg == 2'd1)
            begin
                active_next   = 1'b1;
                fin_pend_next = 1'b1;
                px_next[0]    = win_x_reg[2];
                py_next[0]    = win_y_reg[2];
                px_next[1]    = win_x_reg[2];
                py_next[1]    = win_y_reg[2];
                px_next[2]    = points.point_x;
                py_next[2]    = points.point_y;
                px_next[3]    = points.point_x;
                py_next[3]    = points.point_y;
            end

            win_x_next[0] = win_x_reg[1];
            win_y_next[0] = win_y_reg[1];
            win_x_next[1] = win_x_reg[2];
            win_y_next[1] = win_y_reg[2];
            win_x_next[2] = points.point_x;
            win_y_next[2] = points.point_y;

            if (points.end_of_stroke)
            begin
                ps_next = 2'd0;
            end
            else if (ps_reg != 2'd3)
            begin
                ps_next = ps_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            fin_phase_reg <= 1'b0;
            seg_b_reg     <= 1'b0;
            fin_pend_reg  <= 1'b0;
            j_reg         <= '0;
            ps_reg        <= 2'd0;
            vld_reg       <= '0;
            out_vld_reg   <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else
        begin
            active_reg    <= active_next;
            fin_phase_reg <= fin_phase_next;
            seg_b_reg     <= seg_b_next;
            fin_pend_reg  <= fin_pend_next;
            j_reg         <= j_next;
            ps_reg        <= ps_next;
            win_x_reg     <= win_x_next;
            win_y_reg     <= win_y_next;
            if (advance)
            begin
                vld_reg     <= {vld_reg[LAT-2:0], active_reg};
                out_vld_reg <= vld_reg[LAT-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        if (advance)
        begin
            fin_reg     <= {fin_reg[LAT-2:0], fin_phase_reg};
            out_fin_reg <= fin_reg[LAT-1];
            out_x_reg   <= res_x;
            out_y_reg   <= res_y;
        end
    end

    crpr_lane #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_x (
        .clk     (clk),
        .ctrl    (ctrl),
        .weights (weights),
        .taps    (lane_px),
        .result  (res_x)
    );

    crpr_lane #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_lane_y (
        .clk     (clk),
        .ctrl    (ctrl),
        .weights (weights),
        .taps    (lane_py),
        .result  (res_y)
    );

    assign samples.valid        = out_vld_reg;
    assign samples.sample_x     = out_x_reg;
    assign samples.sample_y     = out_y_reg;
    assign samples.final_sample = out_fin_reg;

`ifndef SYNTH
    a_sample_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (j_reg <= LAST_SAMPLE_IDX))
        else $error("sample index beyond last sample of a segment");

    a_end_point_clean: assert property (@(posedge clk) disable iff (!rst_n)
        fin_phase_reg |-> (j_reg == '0) && !seg_b_reg && !fin_pend_reg)
        else $error("end point emitted with segment work still pending");

    a_end_after_segment: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fin_phase_reg) |-> ($past(j_reg) == LAST_SAMPLE_IDX) && !$past(seg_b_reg))
        else $error("end point started before the closing segment finished");

    a_stroke_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && points.end_of_stroke) |=> (ps_reg == 2'd0))
        else $error("point count not cleared at end of stroke");
`endif

endmodule

`default_nettype wire
